[hdl/nsf_pkg.sv]
// Shared types, constants and helper functions for the NMEA sentence framer.
package nsf_pkg;

    localparam int TAG_LENGTH = 5;
    localparam int TAG_W      = 8 * TAG_LENGTH;
    localparam int POS_W      = $clog2(TAG_LENGTH);

    localparam logic [TAG_W-1:0] FIRST_TAG_RESET  = 40'h4750524D43;
    localparam logic [TAG_W-1:0] SECOND_TAG_RESET = 40'h4750474741;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_9      = 8'h39;

    localparam logic [4:0] FIELD_MAX     = 5'd31;
    localparam logic [4:0] STATUS_FIELD  = 5'd1;
    localparam logic [4:0] FIX_FIELD     = 5'd5;
    localparam logic [4:0] HEX_BAD       = 5'd16;

    localparam logic [0:0] REG_FIRST_TAG  = 1'b0;
    localparam logic [0:0] REG_SECOND_TAG = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAG,
        ST_COMMA,
        ST_DATA,
        ST_HI,
        ST_LO,
        ST_CR,
        ST_LF
    } nsf_step_t;

    typedef enum logic [2:0] {
        OUT_COMPLETE     = 3'd0,
        OUT_UNKNOWN_TAG  = 3'd1,
        OUT_MISSING_COMMA = 3'd2,
        OUT_BAD_CHECKSUM = 3'd3,
        OUT_BAD_TERM     = 3'd4
    } nsf_outcome_t;

    typedef struct packed {
        logic         sentence_kind;
        nsf_outcome_t outcome;
        logic         status_valid;
        logic         fix_valid;
        logic [7:0]   checksum;
    } nsf_result_t;

    function automatic logic [7:0] tag_byte(input logic [TAG_W-1:0] tag,
                                            input logic [POS_W-1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        for (int i = 0; i < TAG_LENGTH; i++) begin
            if (pos == POS_W'(i))
            begin
                b = tag[(TAG_LENGTH-1-i)*8 +: 8];
            end
        end
        return b;
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= CH_0 && c <= CH_9)
        begin
            v = 5'(c - CH_0);
        end
        else if (c >= CH_A && c <= CH_F)
        begin
            v = 5'(c - CH_A + 8'd10);
        end
        else
        begin
            v = HEX_BAD;
        end
        return v;
    endfunction

endpackage

[hdl/nsf_cfg.sv]
// APB register file holding the two sentence tags.
module nsf_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    output logic [nsf_pkg::TAG_W-1:0]    first_tag,
    output logic [nsf_pkg::TAG_W-1:0]    second_tag
);

    logic [nsf_pkg::TAG_W-1:0] first_tag_reg;
    logic [nsf_pkg::TAG_W-1:0] second_tag_reg;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_tag_reg  <= nsf_pkg::FIRST_TAG_RESET;
            second_tag_reg <= nsf_pkg::SECOND_TAG_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:3])
                nsf_pkg::REG_FIRST_TAG:
                begin
                    first_tag_reg <= pwdata[nsf_pkg::TAG_W-1:0];
                end
                nsf_pkg::REG_SECOND_TAG:
                begin
                    second_tag_reg <= pwdata[nsf_pkg::TAG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:3])
            nsf_pkg::REG_SECOND_TAG: prdata = {(64 - nsf_pkg::TAG_W)'(0), second_tag_reg};
            default:                 prdata = {(64 - nsf_pkg::TAG_W)'(0), first_tag_reg};
        endcase
    end

    assign first_tag  = first_tag_reg;
    assign second_tag = second_tag_reg;

endmodule

[hdl/nsf_parser.sv]
// Sentence parse state machine: tag match, field tracking, checksum and terminator checks.
module nsf_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [7:0]                   rx_byte,
    input  logic [nsf_pkg::TAG_W-1:0]    first_tag,
    input  logic [nsf_pkg::TAG_W-1:0]    second_tag,
    output logic                         res_valid,
    output nsf_pkg::nsf_result_t         res
);

    nsf_pkg::nsf_step_t           step_reg, step_next;
    logic [nsf_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [1:0]                   match_reg, match_next;
    logic [7:0]                   parity_reg, parity_next;
    logic [4:0]                   count_reg, count_next;
    logic [7:0]                   ffc_reg, ffc_next;
    logic                         afs_reg, afs_next;
    logic                         status_reg, status_next;
    logic                         fix_reg, fix_next;

    logic                         is_dollar;
    logic [1:0]                   match_now;
    logic                         kind_now;
    logic [7:0]                   ffc_eff;
    logic                         delim;

    assign is_dollar = (rx_byte == nsf_pkg::CH_DOLLAR);
    assign match_now = match_reg &
        {rx_byte == nsf_pkg::tag_byte(second_tag, pos_reg),
         rx_byte == nsf_pkg::tag_byte(first_tag, pos_reg)};
    assign kind_now  = !match_reg[0];
    assign ffc_eff   = afs_reg ? rx_byte : ffc_reg;
    assign delim     = (rx_byte == nsf_pkg::CH_COMMA) || (rx_byte == nsf_pkg::CH_STAR);

    // next state
    always_comb
    begin
        step_next = step_reg;
        pos_next  = pos_reg;
        if (is_dollar)
        begin
            step_next = nsf_pkg::ST_TAG;
            pos_next  = '0;
        end
        else
        begin
            unique case (step_reg)
                nsf_pkg::ST_IDLE:
                begin
                    step_next = nsf_pkg::ST_IDLE;
                end
                nsf_pkg::ST_TAG:
                begin
                    if (match_now == 2'b00)
                    begin
                        step_next = nsf_pkg::ST_IDLE;
                    end
                    else if (pos_reg == nsf_pkg::POS_W'(nsf_pkg::TAG_LENGTH - 1))
                    begin
                        step_next = nsf_pkg::ST_COMMA;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                nsf_pkg::ST_COMMA:
                begin
                    step_next = (rx_byte == nsf_pkg::CH_COMMA) ? nsf_pkg::ST_DATA
                                                                : nsf_pkg::ST_IDLE;
                end
                nsf_pkg::ST_DATA:
                begin
                    if (rx_byte == nsf_pkg::CH_STAR)
                    begin
                        step_next = nsf_pkg::ST_HI;
                    end
                end
                nsf_pkg::ST_HI:
                begin
                    step_next = (nsf_pkg::hex_value(rx_byte) == {1'b0, parity_reg[7:4]})
                                ? nsf_pkg::ST_LO : nsf_pkg::ST_IDLE;
                end
                nsf_pkg::ST_LO:
                begin
                    step_next = (nsf_pkg::hex_value(rx_byte) == {1'b0, parity_reg[3:0]})
                                ? nsf_pkg::ST_CR : nsf_pkg::ST_IDLE;
                end
                nsf_pkg::ST_CR:
                begin
                    step_next = (rx_byte == nsf_pkg::CH_CR) ? nsf_pkg::ST_LF
                                                             : nsf_pkg::ST_IDLE;
                end
                nsf_pkg::ST_LF:
                begin
                    step_next = nsf_pkg::ST_IDLE;
                end
                default:
                begin
                    step_next = nsf_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        match_next  = match_reg;
        parity_next = parity_reg;
        count_next  = count_reg;
        ffc_next    = ffc_reg;
        afs_next    = afs_reg;
        status_next = status_reg;
        fix_next    = fix_reg;
        res_valid   = 1'b0;
        res.sentence_kind = kind_now;
        res.outcome       = nsf_pkg::OUT_COMPLETE;
        res.status_valid  = status_reg;
        res.fix_valid     = fix_reg;
        res.checksum      = parity_reg;
        if (is_dollar)
        begin
            match_next  = 2'b11;
            parity_next = 8'h00;
            count_next  = 5'd0;
            ffc_next    = 8'h00;
            afs_next    = 1'b0;
            status_next = 1'b0;
            fix_next    = 1'b0;
        end
        else
        begin
            unique case (step_reg)
                nsf_pkg::ST_TAG:
                begin
                    parity_next = parity_reg ^ rx_byte;
                    match_next  = match_now;
                    if (match_now == 2'b00)
                    begin
                        res_valid         = 1'b1;
                        res.sentence_kind = 1'b0;
                        res.outcome       = nsf_pkg::OUT_UNKNOWN_TAG;
                        res.checksum      = 8'h00;
                    end
                end
                nsf_pkg::ST_COMMA:
                begin
                    parity_next = parity_reg ^ rx_byte;
                    if (rx_byte != nsf_pkg::CH_COMMA)
                    begin
                        res_valid    = 1'b1;
                        res.outcome  = nsf_pkg::OUT_MISSING_COMMA;
                        res.checksum = 8'h00;
                    end
                    else
                    begin
                        count_next = 5'd0;
                        afs_next   = 1'b1;
                    end
                end
                nsf_pkg::ST_DATA:
                begin
                    if (rx_byte != nsf_pkg::CH_STAR)
                    begin
                        parity_next = parity_reg ^ rx_byte;
                    end
                    ffc_next = ffc_eff;
                    afs_next = 1'b0;
                    if (delim)
                    begin
                        if (match_reg[0])
                        begin
                            if (count_reg == nsf_pkg::STATUS_FIELD && ffc_eff == nsf_pkg::CH_A)
                            begin
                                status_next = 1'b1;
                            end
                        end
                        else if (count_reg == nsf_pkg::FIX_FIELD &&
                                 (ffc_eff == nsf_pkg::CH_1 || ffc_eff == nsf_pkg::CH_2))
                        begin
                            fix_next = 1'b1;
                        end
                        if (count_reg != nsf_pkg::FIELD_MAX)
                        begin
                            count_next = count_reg + 5'd1;
                        end
                        afs_next = 1'b1;
                    end
                end
                nsf_pkg::ST_HI:
                begin
                    if (nsf_pkg::hex_value(rx_byte) != {1'b0, parity_reg[7:4]})
                    begin
                        res_valid   = 1'b1;
                        res.outcome = nsf_pkg::OUT_BAD_CHECKSUM;
                    end
                end
                nsf_pkg::ST_LO:
                begin
                    if (nsf_pkg::hex_value(rx_byte) != {1'b0, parity_reg[3:0]})
                    begin
                        res_valid   = 1'b1;
                        res.outcome = nsf_pkg::OUT_BAD_CHECKSUM;
                    end
                end
                nsf_pkg::ST_CR:
                begin
                    if (rx_byte != nsf_pkg::CH_CR)
                    begin
                        res_valid   = 1'b1;
                        res.outcome = nsf_pkg::OUT_BAD_TERM;
                    end
                end
                nsf_pkg::ST_LF:
                begin
                    res_valid   = 1'b1;
                    res.outcome = (rx_byte == nsf_pkg::CH_LF) ? nsf_pkg::OUT_COMPLETE
                                                               : nsf_pkg::OUT_BAD_TERM;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= nsf_pkg::ST_IDLE;
            pos_reg    <= '0;
            match_reg  <= 2'b00;
            parity_reg <= 8'h00;
            count_reg  <= 5'd0;
            ffc_reg    <= 8'h00;
            afs_reg    <= 1'b0;
            status_reg <= 1'b0;
            fix_reg    <= 1'b0;
        end
        else if (advance)
        begin
            step_reg   <= step_next;
            pos_reg    <= pos_next;
            match_reg  <= match_next;
            parity_reg <= parity_next;
            count_reg  <= count_next;
            ffc_reg    <= ffc_next;
            afs_reg    <= afs_next;
            status_reg <= status_next;
            fix_reg    <= fix_next;
        end
    end

    // tag bytes are only compared while at least one tag still matches
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == nsf_pkg::ST_TAG) |-> (match_reg != 2'b00))
        else $error("tag state with no tag candidate");

    // a sentence past the comma always has a surviving tag
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == nsf_pkg::ST_DATA || step_reg == nsf_pkg::ST_HI ||
         step_reg == nsf_pkg::ST_LO || step_reg == nsf_pkg::ST_CR ||
         step_reg == nsf_pkg::ST_LF) |-> (match_reg != 2'b00))
        else $error("data phase without matched tag");

    // the position counter never runs past the tag
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= nsf_pkg::POS_W'(nsf_pkg::TAG_LENGTH - 1))
        else $error("tag position out of range");

endmodule

[hdl/nmea_sentence_framer.sv]
// Top level of the NMEA sentence framer: input stage, parser, result register, APB tags.
// Takes one received byte per cycle with no bubbles: a byte is captured in an input
// register, parsed by combinational compare/XOR logic, and any result lands in an output
// register, so a byte every cycle is sustained while out_stall is low. A result is held
// in the output register while out_stall is high. in_stall rises only when a byte is
// held and the result register is full and stalled. The tags are written over APB at byte
// address 0 (first tag) and 8 (second tag); write them only while no sentence is in flight.
module nmea_sentence_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        sentence_kind,
    output logic [2:0]  outcome,
    output logic        status_valid,
    output logic        fix_valid,
    output logic [7:0]  checksum,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic                      s1_valid_reg;
    logic [7:0]                s1_byte_reg;
    logic                      out_valid_reg;
    nsf_pkg::nsf_result_t      out_res_reg;
    logic                      advance;
    logic                      res_valid;
    nsf_pkg::nsf_result_t      res;
    logic [nsf_pkg::TAG_W-1:0] first_tag;
    logic [nsf_pkg::TAG_W-1:0] second_tag;

    nsf_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .first_tag  (first_tag),
        .second_tag (second_tag)
    );

    nsf_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .rx_byte    (s1_byte_reg),
        .first_tag  (first_tag),
        .second_tag (second_tag),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sentence_kind = out_res_reg.sentence_kind;
    assign outcome       = out_res_reg.outcome;
    assign status_valid  = out_res_reg.status_valid;
    assign fix_valid     = out_res_reg.fix_valid;
    assign checksum      = out_res_reg.checksum;

    // an unknown tag reports the first kind and a zero checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.outcome == nsf_pkg::OUT_UNKNOWN_TAG)
        |-> (out_res_reg.checksum == 8'h00 && !out_res_reg.sentence_kind))
        else $error("unknown tag result carries data");

    // a stalled input only happens with a byte held in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled without a reason");

    // an accepted item is held in the input stage on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted item lost");

endmodule
